FILE: sv/gtp_pkg.sv
// Shared types, constants and character helpers for the GUID text parser.
`timescale 1ns / 1ps
`default_nettype none

package gtp_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // Digit counting limits
    localparam logic [3:0] DIGIT_SAT    = 4'd13;
    localparam logic [3:0] MAX_FIRST    = 4'd8;
    localparam logic [3:0] MAX_MIDDLE   = 4'd4;
    localparam logic [3:0] MAX_LAST     = 4'd12;
    localparam int unsigned ACC_W       = 48;

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_SKIP = 6'b000001,
        PH_G1   = 6'b000010,
        PH_G2   = 6'b000100,
        PH_G3   = 6'b001000,
        PH_G4   = 6'b010000,
        PH_G5   = 6'b100000
    } phase_t;

    // Parse state kept between bytes
    typedef struct packed {
        phase_t             phase;
        logic [3:0]         digit_count;
        logic [ACC_W-1:0]   group_accum;
        logic [31:0]        saved_first;
        logic [15:0]        saved_second;
        logic [15:0]        saved_third;
        logic [15:0]        saved_fourth;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        phase:        PH_SKIP,
        digit_count:  4'd0,
        group_accum:  '0,
        saved_first:  32'd0,
        saved_second: 16'd0,
        saved_third:  16'd0,
        saved_fourth: 16'd0
    };

    // One result item
    typedef struct packed {
        logic        ok;
        logic [31:0] first_word;
        logic [15:0] second_half;
        logic [15:0] third_half;
        logic [63:0] tail_bytes;
    } result_t;

    // Decode a hex digit: bit 4 set when the byte is a digit, bits 3:0 its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_CR) || (c == CH_SPACE) ||
               (c == CH_TAB) || (c == CH_LF);
    endfunction

endpackage

`default_nettype wire

FILE: sv/gtp_if.sv
// Valid/ready channel interfaces for text bytes in and parsed GUIDs out.
`timescale 1ns / 1ps
`default_nettype none

interface gtp_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface gtp_guid_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] first_word;
    logic [15:0] second_half;
    logic [15:0] third_half;
    logic [63:0] tail_bytes;

    modport source (output valid, output ok, output first_word, output second_half,
                    output third_half, output tail_bytes, input ready);
    modport sink   (input valid, input ok, input first_word, input second_half,
                    input third_half, input tail_bytes, output ready);
endinterface

`default_nettype wire

FILE: sv/gtp_step.sv
// Next-state and result logic for one text byte of the GUID parser.
`timescale 1ns / 1ps
`default_nettype none

module gtp_step (
    input  wire gtp_pkg::state_t  cur,
    input  wire logic [7:0]       text_byte,
    input  wire logic             is_last,
    input  wire logic             guid_style,
    output gtp_pkg::state_t       nxt,
    output logic                  emit,
    output gtp_pkg::result_t      result
);

    logic [4:0]                  hex;
    logic                        is_hex;
    logic [3:0]                  hex_val;
    logic [3:0]                  cnt_inc;
    logic [3:0]                  group_max;
    logic [gtp_pkg::ACC_W-1:0]   acc_shift;
    logic                        good;
    gtp_pkg::state_t             work;

    // Classify the byte
    assign hex     = gtp_pkg::hex_decode(text_byte);
    assign is_hex  = hex[4];
    assign hex_val = hex[3:0];

    // Accumulate a digit, saturating the count
    assign acc_shift = {cur.group_accum[gtp_pkg::ACC_W-5:0], hex_val};
    assign cnt_inc   = (cur.digit_count < gtp_pkg::DIGIT_SAT) ?
                       cur.digit_count + 4'd1 : cur.digit_count;

    // Digit limit of the current group
    always_comb
    begin
        if (cur.phase == gtp_pkg::PH_G1)
            group_max = gtp_pkg::MAX_FIRST;
        else if (cur.phase == gtp_pkg::PH_G5)
            group_max = gtp_pkg::MAX_LAST;
        else
            group_max = gtp_pkg::MAX_MIDDLE;
    end

    // Advance the parse by one byte
    always_comb
    begin
        work = cur;
        emit = 1'b0;
        good = 1'b0;
        unique case (cur.phase) inside
            gtp_pkg::PH_SKIP:
            begin
                if (gtp_pkg::is_space(text_byte))
                begin
                    emit = is_last;
                end
                else if (guid_style || !is_hex)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    work.phase       = gtp_pkg::PH_G1;
                    work.digit_count = 4'd1;
                    work.group_accum = {{(gtp_pkg::ACC_W-4){1'b0}}, hex_val};
                    emit             = is_last;
                end
            end
            gtp_pkg::PH_G1, gtp_pkg::PH_G2, gtp_pkg::PH_G3, gtp_pkg::PH_G4,
            gtp_pkg::PH_G5:
            begin
                if (is_hex)
                begin
                    work.group_accum = acc_shift;
                    work.digit_count = cnt_inc;
                    if (is_last)
                    begin
                        emit = 1'b1;
                        good = (cur.phase == gtp_pkg::PH_G5) &&
                               (cnt_inc <= gtp_pkg::MAX_LAST);
                    end
                end
                else if (cur.digit_count == 4'd0 || cur.digit_count > group_max)
                begin
                    emit = 1'b1;
                end
                else if (cur.phase == gtp_pkg::PH_G5)
                begin
                    emit = 1'b1;
                    good = 1'b1;
                end
                else if (text_byte != gtp_pkg::CH_DASH || is_last)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    // Dash closes the group: save it and open the next one
                    if (cur.phase == gtp_pkg::PH_G1)
                    begin
                        work.saved_first = cur.group_accum[31:0];
                        work.phase       = gtp_pkg::PH_G2;
                    end
                    else if (cur.phase == gtp_pkg::PH_G2)
                    begin
                        work.saved_second = cur.group_accum[15:0];
                        work.phase        = gtp_pkg::PH_G3;
                    end
                    else if (cur.phase == gtp_pkg::PH_G3)
                    begin
                        work.saved_third = cur.group_accum[15:0];
                        work.phase       = gtp_pkg::PH_G4;
                    end
                    else
                    begin
                        work.saved_fourth = cur.group_accum[15:0];
                        work.phase        = gtp_pkg::PH_G5;
                    end
                    work.digit_count = 4'd0;
                    work.group_accum = '0;
                end
            end
            default:
            begin
                emit = 1'b1;
            end
        endcase
    end

    // Build the result; clear the parse once it is delivered
    always_comb
    begin
        if (good)
        begin
            result.ok          = 1'b1;
            result.first_word  = work.saved_first;
            result.second_half = work.saved_second;
            result.third_half  = work.saved_third;
            result.tail_bytes  = {work.saved_fourth, work.group_accum};
        end
        else
        begin
            result = '0;
        end
        nxt = emit ? gtp_pkg::STATE_CLEAR : work;
    end

endmodule

`default_nettype wire

FILE: sv/guid_text_parser.sv
// Top level of the GUID text parser: parse state, style register and result register.
`timescale 1ns / 1ps
`default_nettype none

// Parses GUIDs of five dash-separated hex groups of at most 8-4-4-4-12 digits from a
// byte stream, one byte per request and one request per cycle. Leading whitespace is
// skipped; the byte that ends a parse (or the byte marked is_last) produces one result
// in the cycle after it is taken, with ok set and the five groups on success, or all
// zeros on failure. The parse state updates in the same cycle a byte is taken; the
// single result register can be refilled in the cycle its result is drained, so the
// stream only stalls when a result is still held and the sink is not ready.
// guid_style = 1 makes every parse fail; write it only while the block is idle.
module guid_text_parser (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_en,
    input  wire logic   wr_data,
    gtp_text_if.sink    text_in,
    gtp_guid_if.source  guid_out
);

    gtp_pkg::state_t   state_reg;
    gtp_pkg::state_t   state_next;
    gtp_pkg::result_t  result_reg;
    gtp_pkg::result_t  step_result;
    logic              out_valid_reg;
    logic              guid_style_reg;
    logic              step_emit;
    logic              take;

    // Accept a byte whenever the result register is free or being drained
    assign text_in.ready = !out_valid_reg || guid_out.ready;
    assign take          = text_in.valid && text_in.ready;

    gtp_step u_step (
        .cur        (state_reg),
        .text_byte  (text_in.text_byte),
        .is_last    (text_in.is_last),
        .guid_style (guid_style_reg),
        .nxt        (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // Hold the style register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            guid_style_reg <= 1'b0;
        else if (wr_en)
            guid_style_reg <= wr_data;
    end

    // Advance the parse state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gtp_pkg::STATE_CLEAR;
        else if (take)
            state_reg <= state_next;
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take && step_emit)
            out_valid_reg <= 1'b1;
        else if (guid_out.ready)
            out_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (take && step_emit)
            result_reg <= step_result;
    end

    assign guid_out.valid       = out_valid_reg;
    assign guid_out.ok          = result_reg.ok;
    assign guid_out.first_word  = result_reg.first_word;
    assign guid_out.second_half = result_reg.second_half;
    assign guid_out.third_half  = result_reg.third_half;
    assign guid_out.tail_bytes  = result_reg.tail_bytes;

endmodule

`default_nettype wire

FILE: tb/guid_text_parser_test.sv
// Self-checking testbench for the GUID text parser: directed texts, then random texts.
`timescale 1ns / 1ps

module guid_text_parser_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 8;

    // Kinds of random text
    localparam int TEXT_GOOD   = 0;
    localparam int TEXT_BROKEN = 1;
    localparam int TEXT_NOISE  = 2;

    // Ways to spoil a well-formed GUID
    localparam int FAULT_COUNT = 0;
    localparam int FAULT_SEP   = 1;
    localparam int FAULT_CUT   = 2;

    // Style register settings
    localparam bit STYLE_FIVE_FIELD  = 1'b0;
    localparam bit STYLE_UNSUPPORTED = 1'b1;

    // One directed text: characters packed left to right, right-aligned in the vector
    typedef struct {
        logic [127:0]     chars;
        int               len;
        bit               end_last;
        bit               style;
        bit               typed;
        gtp_pkg::result_t want;
    } text_case_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic wr_data;

    gtp_text_if text_ch ();
    gtp_guid_if guid_ch ();

    guid_text_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .text_in  (text_ch),
        .guid_out (guid_ch)
    );

    // Parse state mirrored from the block
    gtp_pkg::phase_t ps_phase  = gtp_pkg::PH_SKIP;
    logic [3:0]      ps_count  = 4'd0;
    logic [47:0]     ps_accum  = 48'd0;
    logic [31:0]     ps_first  = 32'd0;
    logic [15:0]     ps_second = 16'd0;
    logic [15:0]     ps_third  = 16'd0;
    logic [15:0]     ps_fourth = 16'd0;
    bit              ps_style  = STYLE_FIVE_FIELD;

    gtp_pkg::result_t pending_guids [$];
    logic [8:0]       text_bytes [$];

    int  error_count  = 0;
    int  bytes_sent   = 0;
    int  guids_seen   = 0;
    int  guids_good   = 0;
    int  style_writes = 0;
    bit  steady_flow  = 1'b0;

    text_case_t directed_cases [DIRECTED_ROWS] = '{
        // whitespace of every kind, text ends before any digit
        '{128'h000D0A2009, 5, 1'b1, STYLE_FIVE_FIELD, 1'b1, '0},
        // byte above the ASCII range where a group must start
        '{128'hFF, 1, 1'b0, STYLE_FIVE_FIELD, 1'b1, '0},
        // first group closed by something other than a dash
        '{"1x", 2, 1'b0, STYLE_FIVE_FIELD, 1'b0, '0},
        // too many digits in a middle group
        '{"0-12345-", 8, 1'b0, STYLE_FIVE_FIELD, 1'b0, '0},
        // text ends before the fifth group
        '{"1-2", 3, 1'b1, STYLE_FIVE_FIELD, 1'b0, '0},
        // shortest GUID, text ends on a digit of the fifth group
        '{"F-f-0-9-A", 9, 1'b1, STYLE_FIVE_FIELD, 1'b1,
          '{1'b1, 32'hF, 16'hF, 16'h0, 64'h0009_0000_0000_000A}},
        // shortest GUID closed by a space
        '{"7-a-B-c-D ", 10, 1'b0, STYLE_FIVE_FIELD, 1'b1,
          '{1'b1, 32'h7, 16'hA, 16'hB, 64'h000C_0000_0000_000D}},
        // unsupported style rejects the first non-blank byte
        '{" 5", 2, 1'b0, STYLE_UNSUPPORTED, 1'b1, '0}
    };

    // Decode one hex digit
    function automatic bit hex_nibble(input logic [7:0] ch, output logic [3:0] nib);
        nib = 4'd0;
        if (ch >= "0" && ch <= "9")
        begin
            nib = 4'(ch - "0");
            return 1'b1;
        end
        if (ch >= "a" && ch <= "f")
        begin
            nib = 4'(ch - "a" + 8'd10);
            return 1'b1;
        end
        if (ch >= "A" && ch <= "F")
        begin
            nib = 4'(ch - "A" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit is_blank(input logic [7:0] ch);
        return ch == gtp_pkg::CH_NUL || ch == gtp_pkg::CH_CR || ch == gtp_pkg::CH_SPACE ||
               ch == gtp_pkg::CH_TAB || ch == gtp_pkg::CH_LF;
    endfunction

    function automatic int group_limit(input gtp_pkg::phase_t p);
        case (p)
            gtp_pkg::PH_G1: return int'(gtp_pkg::MAX_FIRST);
            gtp_pkg::PH_G5: return int'(gtp_pkg::MAX_LAST);
            default:        return int'(gtp_pkg::MAX_MIDDLE);
        endcase
    endfunction

    // Advance the mirrored parse by one byte; report whether it ends a parse
    task automatic parse_char(input logic [7:0] ch, input logic last,
                              output bit done, output gtp_pkg::result_t res);
        logic [3:0] nib;
        bit         is_hex;
        bit         good;
        bit         take;
        done   = 1'b0;
        good   = 1'b0;
        take   = 1'b0;
        res    = '0;
        is_hex = hex_nibble(ch, nib);
        if (ps_phase == gtp_pkg::PH_SKIP)
        begin
            if (is_blank(ch))
                done = last;
            else if (ps_style != STYLE_FIVE_FIELD || !is_hex)
                done = 1'b1;
            else
            begin
                ps_phase = gtp_pkg::PH_G1;
                take = 1'b1;
                done = last;
            end
        end
        else if (is_hex)
        begin
            take = 1'b1;
            done = last;
        end
        else if (ps_count == 4'd0 || int'(ps_count) > group_limit(ps_phase))
            done = 1'b1;
        else if (ps_phase == gtp_pkg::PH_G5)
        begin
            done = 1'b1;
            good = 1'b1;
        end
        else if (ch != gtp_pkg::CH_DASH || last)
            done = 1'b1;
        else
        begin
            // close the group and move to the next one
            case (ps_phase)
                gtp_pkg::PH_G1: ps_first  = ps_accum[31:0];
                gtp_pkg::PH_G2: ps_second = ps_accum[15:0];
                gtp_pkg::PH_G3: ps_third  = ps_accum[15:0];
                default:        ps_fourth = ps_accum[15:0];
            endcase
            ps_phase = gtp_pkg::phase_t'({ps_phase[4:0], 1'b0});
            ps_count = 4'd0;
            ps_accum = 48'd0;
        end

        // shift in the digit; the count sticks at its ceiling
        if (take)
        begin
            ps_accum = {ps_accum[43:0], nib};
            if (ps_count < gtp_pkg::DIGIT_SAT)
                ps_count = ps_count + 4'd1;
            if (last)
                good = ps_phase == gtp_pkg::PH_G5 && ps_count >= 4'd1 &&
                       ps_count <= gtp_pkg::MAX_LAST;
        end

        // emit and drop back to skipping whitespace
        if (done)
        begin
            if (good)
                res = '{1'b1, ps_first, ps_second, ps_third, {ps_fourth, ps_accum}};
            ps_phase  = gtp_pkg::PH_SKIP;
            ps_count  = 4'd0;
            ps_accum  = 48'd0;
            ps_first  = 32'd0;
            ps_second = 16'd0;
            ps_third  = 16'd0;
            ps_fourth = 16'd0;
        end
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + 8'(nib);
        if ($urandom_range(0, 1) == 0)
            return "a" + 8'(nib) - 8'd10;
        return "A" + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] ch;
        logic [3:0] nib;
        do
            ch = 8'($urandom_range(0, 255));
        while (hex_nibble(ch, nib));
        return ch;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 4))
            0:       return gtp_pkg::CH_NUL;
            1:       return gtp_pkg::CH_CR;
            2:       return gtp_pkg::CH_TAB;
            3:       return gtp_pkg::CH_LF;
            default: return gtp_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic int limit_of(input int g);
        if (g == 0)
            return int'(gtp_pkg::MAX_FIRST);
        if (g == 4)
            return int'(gtp_pkg::MAX_LAST);
        return int'(gtp_pkg::MAX_MIDDLE);
    endfunction

    // Queue one GUID, well formed or spoiled in one place
    task automatic queue_guid(input bit broken);
        int         cnt [5];
        logic [7:0] sep [4];
        int         bad_group;
        int         fault;
        int         fill;
        int         start;
        int         idx;
        int         r;
        logic [3:0] nib;
        logic [8:0] entry;
        bad_group = $urandom_range(0, 4);
        fault     = $urandom_range(FAULT_COUNT, FAULT_CUT);
        start     = text_bytes.size();
        repeat ($urandom_range(0, 2))
            text_bytes.push_back({1'b0, blank_char()});

        // digit counts lean towards the full width and the single digit
        for (int g = 0; g < 5; g++)
        begin
            r = $urandom_range(0, 9);
            cnt[g] = (r < 4) ? limit_of(g) : (r < 6) ? 1 : $urandom_range(1, limit_of(g));
            if (g < 4)
                sep[g] = gtp_pkg::CH_DASH;
        end

        if (broken && fault == FAULT_COUNT)
            cnt[bad_group] = ($urandom_range(0, 2) == 0) ? 0
                             : limit_of(bad_group) + $urandom_range(1, 6);
        if (broken && fault == FAULT_SEP)
        begin
            sep[bad_group % 4] = non_hex_char();
            if (sep[bad_group % 4] == gtp_pkg::CH_DASH)
                sep[bad_group % 4] = "/";
        end

        for (int g = 0; g < 5; g++)
        begin
            fill = $urandom_range(0, 7);
            for (int k = 0; k < cnt[g]; k++)
            begin
                nib = (fill == 0) ? 4'hF : (fill == 1) ? 4'h0 : 4'($urandom_range(0, 15));
                text_bytes.push_back({1'b0, hex_char(nib)});
            end
            if (g < 4)
                text_bytes.push_back({1'b0, sep[g]});
        end

        // end on the last digit or on a closing byte
        if (cnt[4] > 0 && $urandom_range(0, 1) == 0)
        begin
            entry = text_bytes.pop_back();
            entry[8] = 1'b1;
            text_bytes.push_back(entry);
        end
        else
            text_bytes.push_back({1'b0, non_hex_char()});

        if (broken && fault == FAULT_CUT)
        begin
            idx = $urandom_range(start, text_bytes.size() - 1);
            entry = text_bytes[idx];
            entry[8] = 1'b1;
            text_bytes[idx] = entry;
        end
    endtask

    // Offer one byte, wait for the request to be taken, predict its result
    task automatic send_byte(input logic [7:0] ch, input logic last,
                             input bit use_want, input gtp_pkg::result_t want);
        int               gap;
        bit               done;
        gtp_pkg::result_t res;
        gap = steady_flow ? 0 : idle_length();
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= ch;
        text_ch.is_last   <= last;
        do
            @(posedge clk);
        while (!text_ch.ready);
        bytes_sent++;
        parse_char(ch, last, done, res);
        if (done)
            pending_guids.push_back(use_want ? want : res);
    endtask

    task automatic send_text();
        logic [8:0] entry;
        while (text_bytes.size() > 0)
        begin
            entry = text_bytes.pop_front();
            send_byte(entry[7:0], entry[8], 1'b0, '0);
        end
    endtask

    // Write the style register once every result is out and the block is quiet
    task automatic write_style(input bit value);
        text_ch.valid <= 1'b0;
        while (pending_guids.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(posedge clk);
        wr_en    <= 1'b0;
        ps_style = value;
        style_writes++;
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Take results with random back-pressure and check each against the oldest prediction
    initial
    begin : result_monitor
        int               stall;
        gtp_pkg::result_t want;
        gtp_pkg::result_t got;
        stall = 0;
        guid_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && guid_ch.valid && guid_ch.ready)
            begin
                got = '{guid_ch.ok, guid_ch.first_word, guid_ch.second_half,
                        guid_ch.third_half, guid_ch.tail_bytes};
                guids_seen++;
                if (got.ok)
                    guids_good++;
                if (pending_guids.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = pending_guids.pop_front();
                    compare_field("ok", 64'(want.ok), 64'(got.ok));
                    compare_field("first_word", 64'(want.first_word), 64'(got.first_word));
                    compare_field("second_half", 64'(want.second_half), 64'(got.second_half));
                    compare_field("third_half", 64'(want.third_half), 64'(got.third_half));
                    compare_field("tail_bytes", want.tail_bytes, got.tail_bytes);
                end
            end
            if (stall > 0)
            begin
                guid_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                guid_ch.ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 99) < 30)
                    stall = idle_length();
            end
        end
    end

    // Stop the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((text_ch.valid && text_ch.ready) || (guid_ch.valid && guid_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("guid_text_parser_test: done, errors");
                $finish;
            end
        end
    end

    // Reset, directed texts, random texts, drain and verdict
    initial
    begin : stimulus
        bit   style_plan [5];
        int   phase_bytes [5];
        int   first_byte;
        int   kind;
        int   r;
        logic [7:0] ch;
        style_plan  = '{STYLE_FIVE_FIELD, STYLE_UNSUPPORTED, STYLE_FIVE_FIELD,
                        STYLE_UNSUPPORTED, STYLE_FIVE_FIELD};
        phase_bytes = '{500, 150, 500, 100, 300};

        rst_n             <= 1'b0;
        wr_en             <= 1'b0;
        wr_data           <= 1'b0;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= 8'd0;
        text_ch.is_last   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_style(STYLE_FIVE_FIELD);

        // walk the directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_cases[i].style != ps_style)
                write_style(directed_cases[i].style);
            for (int k = 0; k < directed_cases[i].len; k++)
            begin
                ch = directed_cases[i].chars[(directed_cases[i].len - 1 - k) * 8 +: 8];
                send_byte(ch, directed_cases[i].end_last && k == directed_cases[i].len - 1,
                          directed_cases[i].typed && k == directed_cases[i].len - 1,
                          directed_cases[i].want);
            end
        end

        // random texts under each style setting
        for (int p = 0; p < 5; p++)
        begin
            write_style(style_plan[p]);
            first_byte = bytes_sent;
            while (bytes_sent - first_byte < phase_bytes[p])
            begin
                steady_flow = ($urandom_range(0, 9) == 0);
                r = $urandom_range(0, 9);
                kind = (r < 7) ? TEXT_GOOD : (r < 9) ? TEXT_BROKEN : TEXT_NOISE;
                if (kind == TEXT_NOISE)
                begin
                    repeat ($urandom_range(1, 6))
                        text_bytes.push_back({$urandom_range(0, 7) == 0,
                                              8'($urandom_range(0, 255))});
                end
                else
                    queue_guid(kind == TEXT_BROKEN);
                send_text();
            end
            // close the text so the parse is back at rest before the next write
            steady_flow = 1'b0;
            send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        end

        text_ch.valid <= 1'b0;
        while (pending_guids.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d text bytes over %0d style writes;", bytes_sent, style_writes);
        $display("checked %0d results, %0d good GUIDs", guids_seen, guids_good);
        if (error_count == 0)
            $display("guid_text_parser_test: done, clean");
        else
            $display("guid_text_parser_test: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/gtp_pkg.sv
sv/gtp_if.sv
sv/gtp_step.sv
sv/guid_text_parser.sv
tb/guid_text_parser_test.sv
